FILE: sv/owrse_pkg.sv
// ----------------------------------------------------------------------------
// 1-Wire ROM search engine package
// Transaction types, search state record, request and bus action codes.
// ----------------------------------------------------------------------------
package owrse_pkg;

  localparam logic [2:0] REQ_FIRST       = 3'd0;
  localparam logic [2:0] REQ_NEXT        = 3'd1;
  localparam logic [2:0] REQ_VERIFY      = 3'd2;
  localparam logic [2:0] REQ_TARGET_FAM  = 3'd3;
  localparam logic [2:0] REQ_SKIP_FAM    = 3'd4;
  localparam logic [2:0] REQ_RESET_RESP  = 3'd5;
  localparam logic [2:0] REQ_BIT_PAIR    = 3'd6;

  localparam logic [2:0] ACT_NONE        = 3'd0;
  localparam logic [2:0] ACT_BUS_RESET   = 3'd1;
  localparam logic [2:0] ACT_SEARCH_CMD  = 3'd2;
  localparam logic [2:0] ACT_WRITE_READ  = 3'd3;
  localparam logic [2:0] ACT_WRITE_ONLY  = 3'd4;

  localparam logic [6:0] ROM_BITS        = 7'd64;
  localparam logic [6:0] FAMILY_BITS     = 7'd9;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_RESET = 3'b010,
    PH_BITS  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] fam_byte;
    logic       no_presence;
    logic       id_bit;
    logic       cmp_bit;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  bus_action;
    logic        direction_bit;
    logic        done_res;
    logic        found;
    logic [63:0] rom_id;
    logic        last_device;
  } out_item_t;

  typedef struct packed {
    logic [63:0] rom_number;
    logic [6:0]  last_disc;
    logic [3:0]  last_fam_disc;
    logic        last_dev;
    logic [6:0]  bit_pos;
    logic [6:0]  zero_pos;
    logic [7:0]  crc;
    phase_t      phase;
    logic        verify;
    logic [63:0] saved_rom;
    logic [6:0]  saved_disc;
    logic [3:0]  saved_fam_disc;
    logic        saved_last;
  } owrse_state_t;

endpackage

FILE: sv/owrse_step.sv
// ----------------------------------------------------------------------------
// 1-Wire ROM search step
// Next search state and result for one request or bus response.
// ----------------------------------------------------------------------------
module owrse_step (
  input  owrse_pkg::owrse_state_t state_i,
  input  owrse_pkg::in_item_t     item_i,
  output owrse_pkg::owrse_state_t state_o,
  output owrse_pkg::out_item_t    res_o
);
  import owrse_pkg::*;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    c = crc_in ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ 8'h8C;
      else      c = c >> 1;
    end
    return c;
  endfunction

  function automatic owrse_state_t restore(input owrse_state_t st);
    owrse_state_t r;
    r               = st;
    r.rom_number    = st.saved_rom;
    r.last_disc     = st.saved_disc;
    r.last_fam_disc = st.saved_fam_disc;
    r.last_dev      = st.saved_last;
    return r;
  endfunction

  // Outcome of ending a search, taken before the state is closed
  function automatic logic finish_found(input owrse_state_t st, input logic ok);
    logic good;
    good = ok && (st.rom_number[7:0] != 8'd0);
    if (st.verify) return good && (st.rom_number == st.saved_rom);
    return good;
  endfunction

  function automatic owrse_state_t finish_state(input owrse_state_t st, input logic ok);
    owrse_state_t r;
    r = st;
    if (ok) begin
      r.last_disc = r.zero_pos;
      if (r.zero_pos == 7'd0) r.last_dev = 1'b1;
    end
    if (!ok || r.rom_number[7:0] == 8'd0) begin
      r.last_disc     = 7'd0;
      r.last_fam_disc = 4'd0;
      r.last_dev      = 1'b0;
    end
    if (r.verify) begin
      r        = restore(r);
      r.verify = 1'b0;
    end
    r.phase = PH_IDLE;
    return r;
  endfunction

  owrse_state_t s;
  logic [2:0]   action;
  logic         dir;
  logic         done;
  logic         fnd;
  logic [5:0]   idx;
  logic [6:0]   pos_inc;

  always_comb begin
    s       = state_i;
    action  = ACT_NONE;
    dir     = 1'b0;
    done    = 1'b0;
    fnd     = 1'b0;
    idx     = 6'(state_i.bit_pos - 7'd1);
    pos_inc = state_i.bit_pos + 7'd1;

    // Any search request drops a running search first
    if (item_i.req_type <= REQ_SKIP_FAM) begin
      if (s.phase != PH_IDLE && s.verify) s = restore(s);
      s.verify = 1'b0;
      s.phase  = PH_IDLE;
    end

    unique case (item_i.req_type)
      REQ_FIRST, REQ_NEXT, REQ_VERIFY: begin
        if (item_i.req_type == REQ_FIRST) begin
          s.last_disc     = 7'd0;
          s.last_fam_disc = 4'd0;
          s.last_dev      = 1'b0;
        end
        if (item_i.req_type == REQ_VERIFY) begin
          s.saved_rom      = s.rom_number;
          s.saved_disc     = s.last_disc;
          s.saved_fam_disc = s.last_fam_disc;
          s.saved_last     = s.last_dev;
          s.last_disc      = ROM_BITS;
          s.last_dev       = 1'b0;
          s.verify         = 1'b1;
        end
        if (s.last_dev) begin
          fnd  = finish_found(s, 1'b0);
          s    = finish_state(s, 1'b0);
          done = 1'b1;
        end else begin
          s.phase = PH_RESET;
          action  = ACT_BUS_RESET;
        end
      end
      REQ_TARGET_FAM: begin
        s.rom_number    = {56'd0, item_i.fam_byte};
        s.last_disc     = ROM_BITS;
        s.last_fam_disc = 4'd0;
        s.last_dev      = 1'b0;
        done            = 1'b1;
      end
      REQ_SKIP_FAM: begin
        s.last_disc     = {3'd0, s.last_fam_disc};
        s.last_fam_disc = 4'd0;
        if (s.last_disc == 7'd0) s.last_dev = 1'b1;
        done            = 1'b1;
      end
      REQ_RESET_RESP: begin
        if (s.phase == PH_RESET) begin
          if (item_i.no_presence) begin
            fnd  = finish_found(s, 1'b0);
            s    = finish_state(s, 1'b0);
            done = 1'b1;
          end else begin
            s.bit_pos  = 7'd1;
            s.zero_pos = 7'd0;
            s.crc      = 8'd0;
            s.phase    = PH_BITS;
            action     = ACT_SEARCH_CMD;
          end
        end
      end
      REQ_BIT_PAIR: begin
        if (s.phase == PH_BITS && s.bit_pos >= 7'd1 && s.bit_pos <= ROM_BITS) begin
          if (item_i.id_bit && item_i.cmp_bit) begin
            fnd  = finish_found(s, 1'b0);
            s    = finish_state(s, 1'b0);
            done = 1'b1;
          end else begin
            if (item_i.id_bit != item_i.cmp_bit) begin
              dir = item_i.id_bit;
            end else begin
              if (s.bit_pos < s.last_disc) dir = s.rom_number[idx];
              else                         dir = (s.bit_pos == s.last_disc);
              if (!dir) begin
                s.zero_pos = s.bit_pos;
                if (s.bit_pos < FAMILY_BITS) s.last_fam_disc = s.bit_pos[3:0];
              end
            end
            s.rom_number[idx] = dir;
            // Fold each completed byte into the CRC
            if (idx[2:0] == 3'd7)
              s.crc = crc8_byte(s.crc, s.rom_number[{idx[5:3], 3'd0} +: 8]);
            s.bit_pos = pos_inc;
            if (pos_inc > ROM_BITS) begin
              fnd    = finish_found(s, s.crc == 8'd0);
              s      = finish_state(s, s.crc == 8'd0);
              done   = 1'b1;
              action = ACT_WRITE_ONLY;
            end else begin
              action = ACT_WRITE_READ;
            end
          end
        end
      end
      default: begin
      end
    endcase

    state_o             = s;
    res_o.bus_action    = action;
    res_o.direction_bit = dir;
    res_o.done_res      = done;
    res_o.found         = fnd;
    res_o.rom_id        = s.rom_number;
    res_o.last_device   = s.last_dev;
  end

endmodule

FILE: sv/one_wire_rom_search_engine_core.sv
// ----------------------------------------------------------------------------
// 1-Wire ROM search engine core
// Binary-tree ROM search controller sitting above a bit-level bus master.
// ----------------------------------------------------------------------------
// Usage:
//   in_data carries a search request (first, next, verify, target family,
//   skip family) or a bus response (reset presence, one read bit pair).
//   Every accepted transaction yields exactly one out_data transaction that
//   tells the bus master what to do next (bus reset, send the search byte,
//   write the direction bit) and, at the end of a search, reports found,
//   the ROM number and the last-device flag.
//   out_valid rises once a transaction has passed from the input register
//   via one pass of the search step into the result register. Throughput:
//   one transaction per cycle unless out_stall; the search state feeds
//   back via a single register stage, so responses may run back to back.
//   The input register keeps taking a transaction while a finished result
//   waits under out_stall; in_stall rises only when both registers are full.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   search state to idle with the ROM number and discrepancies cleared.
// ----------------------------------------------------------------------------
module one_wire_rom_search_engine_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  owrse_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output owrse_pkg::out_item_t out_data
);
  import owrse_pkg::*;

  logic         in_vld_r;
  in_item_t     in_item_r;
  logic         out_vld_r;
  out_item_t    out_item_r;
  owrse_state_t state_r;
  owrse_state_t state_nxt;
  out_item_t    res_nxt;
  logic         advance;
  logic         fire;

  assign advance  = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  owrse_step u_step (
    .state_i (state_r),
    .item_i  (in_item_r),
    .state_o (state_nxt),
    .res_o   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_item_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{bit_pos: 7'd1, phase: PH_IDLE, default: '0};
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // A verify in progress always has a search running
  a_verify_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.verify |-> state_r.phase != PH_IDLE)
    else $error("verify flag set with no search running");

  // Bit position stays on the ROM while reading pairs
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_BITS |-> (state_r.bit_pos >= 7'd1 && state_r.bit_pos <= ROM_BITS))
    else $error("bit position off the ROM during bit reads");

  // A bit pair outside the read phase leaves the state alone
  a_stray_pair: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_item_r.req_type == REQ_BIT_PAIR && state_r.phase != PH_BITS
    |=> state_r == $past(state_r))
    else $error("stray bit pair changed the search state");

  // Only a final status may report found
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_item_r.found |-> out_item_r.done_res)
    else $error("found reported without final status");

  // Target family arms a full search from the given family byte
  a_target: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_item_r.req_type == REQ_TARGET_FAM
    |=> state_r.last_disc == ROM_BITS && state_r.phase == PH_IDLE)
    else $error("target family set-up not applied");

endmodule

FILE: bench/one_wire_rom_search_engine_core_test.sv
// ----------------------------------------------------------------------------
// 1-Wire ROM search engine core testbench
// Sends search requests and bus responses from a simulated population of up
// to four devices, predicts every bus action and ROM report in step with the
// accepted transactions, and compares each result field by field.
// ----------------------------------------------------------------------------
module one_wire_rom_search_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import owrse_pkg::*;

  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int unsigned N_ITEMS = 950;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;

  typedef struct packed {
    in_item_t  stim;
    logic      known;
    out_item_t want;
  } probe_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // predicted search state
  logic [63:0] rom_q;
  logic [6:0]  disc_q;
  logic [3:0]  fam_disc_q;
  logic        last_q;
  logic [6:0]  pos_q;
  logic [6:0]  zero_q;
  logic [7:0]  crc_q;
  phase_t      phase_q;
  logic        verify_q;
  logic [63:0] saved_rom_q;
  logic [6:0]  saved_disc_q;
  logic [3:0]  saved_fam_q;
  logic        saved_last_q;

  // simulated devices on the bus
  logic [63:0] bus_rom [4];
  int unsigned bus_count;
  logic [3:0]  alive;

  out_item_t   pending_actions [$];
  out_item_t   head;
  probe_t      probes [$];
  int unsigned counted;
  int unsigned seen = 0;
  int unsigned calm_left;
  int          errors = 0;
  bit          hold_off = 1'b0;
  bit          held_once = 1'b0;

  one_wire_rom_search_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
    return c;
  endfunction

  function automatic void clear_tree();
    disc_q = '0;
    last_q = 1'b0;
    fam_disc_q = '0;
  endfunction

  function automatic void restore_tree();
    rom_q = saved_rom_q;
    disc_q = saved_disc_q;
    fam_disc_q = saved_fam_q;
    last_q = saved_last_q;
  endfunction

  function automatic out_item_t respond(logic [2:0] act, logic dir, logic done, logic fnd);
    out_item_t o;
    o.bus_action = act;
    o.direction_bit = dir;
    o.done_res = done;
    o.found = fnd;
    o.rom_id = rom_q;
    o.last_device = last_q;
    return o;
  endfunction

  // Close the running search and return the found status.
  function automatic logic end_search(logic ok);
    logic fnd;
    if (ok) begin
      disc_q = zero_q;
      if (disc_q == 7'd0) last_q = 1'b1;
    end
    if (!ok || rom_q[7:0] == 8'h00) begin
      clear_tree();
      ok = 1'b0;
    end
    fnd = ok;
    if (verify_q) begin
      fnd = ok && (rom_q == saved_rom_q);
      restore_tree();
      verify_q = 1'b0;
    end
    phase_q = PH_IDLE;
    return fnd;
  endfunction

  function automatic out_item_t open_search();
    logic fnd;
    if (last_q) begin
      fnd = end_search(1'b0);
      return respond(ACT_NONE, 1'b0, 1'b1, fnd);
    end
    phase_q = PH_RESET;
    return respond(ACT_BUS_RESET, 1'b0, 1'b0, 1'b0);
  endfunction

  function automatic out_item_t search_step(in_item_t it);
    logic       fnd;
    logic       dir;
    logic [5:0] idx;
    out_item_t  o;
    // any request drops a search in flight
    if (it.req_type <= REQ_SKIP_FAM) begin
      if (phase_q != PH_IDLE && verify_q) restore_tree();
      verify_q = 1'b0;
      phase_q = PH_IDLE;
    end
    case (it.req_type)
      REQ_FIRST: begin
        clear_tree();
        o = open_search();
      end
      REQ_NEXT: o = open_search();
      REQ_VERIFY: begin
        saved_rom_q = rom_q;
        saved_disc_q = disc_q;
        saved_fam_q = fam_disc_q;
        saved_last_q = last_q;
        disc_q = ROM_BITS;
        last_q = 1'b0;
        verify_q = 1'b1;
        o = open_search();
      end
      REQ_TARGET_FAM: begin
        rom_q = {56'd0, it.fam_byte};
        disc_q = ROM_BITS;
        fam_disc_q = '0;
        last_q = 1'b0;
        o = respond(ACT_NONE, 1'b0, 1'b1, 1'b0);
      end
      REQ_SKIP_FAM: begin
        disc_q = {3'b000, fam_disc_q};
        fam_disc_q = '0;
        if (disc_q == 7'd0) last_q = 1'b1;
        o = respond(ACT_NONE, 1'b0, 1'b1, 1'b0);
      end
      REQ_RESET_RESP: begin
        if (phase_q != PH_RESET) begin
          o = respond(ACT_NONE, 1'b0, 1'b0, 1'b0);
        end else if (it.no_presence) begin
          fnd = end_search(1'b0);
          o = respond(ACT_NONE, 1'b0, 1'b1, fnd);
        end else begin
          pos_q = 7'd1;
          zero_q = 7'd0;
          crc_q = 8'h00;
          phase_q = PH_BITS;
          o = respond(ACT_SEARCH_CMD, 1'b0, 1'b0, 1'b0);
        end
      end
      REQ_BIT_PAIR: begin
        if (phase_q != PH_BITS || pos_q < 7'd1 || pos_q > ROM_BITS) begin
          o = respond(ACT_NONE, 1'b0, 1'b0, 1'b0);
        end else if (it.id_bit && it.cmp_bit) begin
          fnd = end_search(1'b0);
          o = respond(ACT_NONE, 1'b0, 1'b1, fnd);
        end else begin
          idx = pos_q[5:0] - 6'd1;
          if (it.id_bit != it.cmp_bit) begin
            dir = it.id_bit;
          end else begin
            // devices disagree: follow the previous path up to the last fork
            if (pos_q < disc_q) dir = rom_q[idx];
            else dir = (pos_q == disc_q);
            if (!dir) begin
              zero_q = pos_q;
              if (zero_q < FAMILY_BITS) fam_disc_q = zero_q[3:0];
            end
          end
          rom_q[idx] = dir;
          if (idx[2:0] == 3'd7) crc_q = crc8_step(crc_q, rom_q[{idx[5:3], 3'b000} +: 8]);
          pos_q = pos_q + 7'd1;
          if (pos_q > ROM_BITS) begin
            fnd = end_search(crc_q == 8'h00);
            o = respond(ACT_WRITE_ONLY, dir, 1'b1, fnd);
          end else begin
            o = respond(ACT_WRITE_READ, dir, 1'b0, 1'b0);
          end
        end
      end
      default: o = respond(ACT_NONE, 1'b0, 1'b0, 1'b0);
    endcase
    return o;
  endfunction

  function automatic in_item_t stim_of(logic [2:0] rq, logic [7:0] fam, logic np,
                                       logic idb, logic cmpb);
    return {rq, fam, np, idb, cmpb};
  endfunction

  function automatic out_item_t action_of(logic [2:0] act, logic dir, logic done,
                                          logic fnd, logic [63:0] rom, logic last);
    return {act, dir, done, fnd, rom, last};
  endfunction

  function automatic in_item_t noise_of(logic [2:0] rq);
    return stim_of(rq, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [63:0] make_rom(logic [7:0] fam);
    logic [63:0] r;
    logic [7:0]  c;
    r[7:0] = fam;
    r[39:8] = $urandom();
    r[55:40] = 16'($urandom_range(0, 65535));
    c = 8'h00;
    for (int b = 0; b < 7; b++) c = crc8_step(c, r[8*b +: 8]);
    r[63:56] = c;
    if ($urandom_range(0, 9) == 0) r[63:56] = c ^ 8'($urandom_range(1, 255));
    return r;
  endfunction

  task automatic populate_bus();
    logic [7:0] fam;
    bus_count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    for (int i = 0; i < int'(bus_count); i++) begin
      if (i > 0 && $urandom_range(0, 2) == 0) fam = bus_rom[i-1][7:0];
      else if ($urandom_range(0, 11) == 0) fam = 8'h00;
      else fam = 8'($urandom_range(1, 255));
      bus_rom[i] = make_rom(fam);
    end
  endtask

  task automatic plan(input in_item_t s, input logic k, input out_item_t w);
    probe_t p;
    p.stim = s;
    p.known = k;
    p.want = w;
    probes.push_back(p);
  endtask

  // Offer one transaction, hold it until taken, then predict its result.
  task automatic send(input in_item_t it, input logic known, input out_item_t typed_want,
                      output out_item_t pred);
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = search_step(it);
    pending_actions.push_back(known ? typed_want : pred);
    counted++;
  endtask

  task automatic sender_gap();
    int unsigned r;
    int unsigned gap;
    gap = 0;
    if (hold_off) return;
    if (calm_left > 0) begin
      calm_left--;
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm_left = $urandom_range(30, 80);
    else if (r < 55) gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(15, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_actions.size() != 0) @(posedge clk);
  endtask

  // One search as the bus would answer it, with the odd fault thrown in.
  task automatic run_search(input logic [2:0] rq);
    out_item_t  pred;
    logic       idb;
    logic       cmpb;
    logic       np;
    logic [5:0] idx;
    bit         finished;
    send(noise_of(rq), 1'b0, '0, pred);
    sender_gap();
    if (pred.bus_action != ACT_BUS_RESET || $urandom_range(0, 19) == 0) return;
    np = (bus_count == 0);
    if ($urandom_range(0, 24) == 0) np = ~np;
    send(stim_of(REQ_RESET_RESP, 8'($urandom_range(0, 255)), np, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1))), 1'b0, '0, pred);
    sender_gap();
    if (pred.bus_action != ACT_SEARCH_CMD) return;
    alive = '0;
    for (int i = 0; i < int'(bus_count); i++) alive[i] = 1'b1;
    finished = 0;
    while (!finished) begin
      if ($urandom_range(0, 199) == 0) begin
        send(noise_of($urandom_range(0, 1) ? REQ_UNUSED : REQ_RESET_RESP), 1'b0, '0, pred);
        sender_gap();
      end
      // break off now and then; the next request abandons the search
      if ($urandom_range(0, 299) == 0) return;
      idx = pos_q[5:0] - 6'd1;
      idb = 1'b1;
      cmpb = 1'b1;
      for (int i = 0; i < int'(bus_count); i++) begin
        if (alive[i]) begin
          idb &= bus_rom[i][idx];
          cmpb &= ~bus_rom[i][idx];
        end
      end
      if ($urandom_range(0, 149) == 0) begin
        idb = 1'($urandom_range(0, 1));
        cmpb = 1'($urandom_range(0, 1));
      end
      send(stim_of(REQ_BIT_PAIR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   idb, cmpb), 1'b0, '0, pred);
      sender_gap();
      if (pred.done_res) begin
        finished = 1;
      end else begin
        for (int i = 0; i < int'(bus_count); i++)
          if (bus_rom[i][idx] != pred.direction_bit) alive[i] = 1'b0;
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen++;
      if (pending_actions.size() == 0) begin
        $display("%0t: unexpected result, got %p", $time, out_data);
        errors++;
      end else begin
        head = pending_actions.pop_front();
        compare_field("bus_action", 64'(head.bus_action), 64'(out_data.bus_action));
        compare_field("direction_bit", 64'(head.direction_bit), 64'(out_data.direction_bit));
        compare_field("done_res", 64'(head.done_res), 64'(out_data.done_res));
        compare_field("found", 64'(head.found), 64'(out_data.found));
        compare_field("rom_id", head.rom_id, out_data.rom_id);
        compare_field("last_device", 64'(head.last_device), 64'(out_data.last_device));
      end
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off.
  initial begin
    int unsigned r;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_once && seen >= 300) begin
        held_once = 1;
        hold_off = 1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end else if (r < 50) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else if (r < 95) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(8, 30)) @(posedge clk);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    out_item_t   pred;
    int unsigned r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    counted = 0;
    calm_left = 0;
    rom_q = '0;
    disc_q = '0;
    fam_disc_q = '0;
    last_q = 1'b0;
    pos_q = 7'd1;
    zero_q = '0;
    crc_q = '0;
    phase_q = PH_IDLE;
    verify_q = 1'b0;
    saved_rom_q = '0;
    saved_disc_q = '0;
    saved_fam_q = '0;
    saved_last_q = 1'b0;

    // out-of-phase responses and setup requests from reset
    plan(stim_of(REQ_BIT_PAIR, 8'h00, 1'b0, 1'b1, 1'b1), 1'b1,
         action_of(ACT_NONE, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0));
    plan(stim_of(REQ_RESET_RESP, 8'h00, 1'b1, 1'b0, 1'b0), 1'b1,
         action_of(ACT_NONE, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0));
    plan(stim_of(REQ_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1), 1'b1,
         action_of(ACT_NONE, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0));
    plan(stim_of(REQ_TARGET_FAM, 8'hFF, 1'b0, 1'b0, 1'b0), 1'b1,
         action_of(ACT_NONE, 1'b0, 1'b1, 1'b0, 64'hFF, 1'b0));
    plan(stim_of(REQ_SKIP_FAM, 8'h00, 1'b0, 1'b0, 1'b0), 1'b1,
         action_of(ACT_NONE, 1'b0, 1'b1, 1'b0, 64'hFF, 1'b1));
    // search after the last device
    plan(stim_of(REQ_NEXT, 8'h00, 1'b0, 1'b0, 1'b0), 1'b1,
         action_of(ACT_NONE, 1'b0, 1'b1, 1'b0, 64'hFF, 1'b0));
    plan(stim_of(REQ_TARGET_FAM, 8'h00, 1'b0, 1'b0, 1'b0), 1'b1,
         action_of(ACT_NONE, 1'b0, 1'b1, 1'b0, 64'h0, 1'b0));
    plan(stim_of(REQ_FIRST, 8'h00, 1'b0, 1'b0, 1'b0), 1'b1,
         action_of(ACT_BUS_RESET, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0));
    plan(stim_of(REQ_RESET_RESP, 8'h00, 1'b1, 1'b0, 1'b0), 1'b1,
         action_of(ACT_NONE, 1'b0, 1'b1, 1'b0, 64'h0, 1'b0));
    plan(stim_of(REQ_FIRST, 8'h00, 1'b0, 1'b0, 1'b0), 1'b1,
         action_of(ACT_BUS_RESET, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0));
    plan(stim_of(REQ_BIT_PAIR, 8'h00, 1'b0, 1'b0, 1'b1), 1'b1,
         action_of(ACT_NONE, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0));
    plan(stim_of(REQ_RESET_RESP, 8'h00, 1'b0, 1'b0, 1'b0), 1'b1,
         action_of(ACT_SEARCH_CMD, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0));
    plan(stim_of(REQ_RESET_RESP, 8'h00, 1'b1, 1'b0, 1'b0), 1'b1,
         action_of(ACT_NONE, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0));
    // bit pairs of every kind, both-ones ending the search
    plan(stim_of(REQ_BIT_PAIR, 8'h00, 1'b0, 1'b1, 1'b0), 1'b0, '0);
    plan(stim_of(REQ_BIT_PAIR, 8'h00, 1'b0, 1'b0, 1'b1), 1'b0, '0);
    plan(stim_of(REQ_BIT_PAIR, 8'h00, 1'b0, 1'b0, 1'b0), 1'b0, '0);
    plan(stim_of(REQ_BIT_PAIR, 8'h00, 1'b0, 1'b1, 1'b1), 1'b0, '0);
    // verify dropped by a new request, then one with no presence
    plan(stim_of(REQ_VERIFY, 8'h00, 1'b0, 1'b0, 1'b0), 1'b0, '0);
    plan(stim_of(REQ_RESET_RESP, 8'h00, 1'b0, 1'b0, 1'b0), 1'b0, '0);
    plan(stim_of(REQ_BIT_PAIR, 8'h00, 1'b0, 1'b0, 1'b0), 1'b0, '0);
    plan(stim_of(REQ_FIRST, 8'hFF, 1'b0, 1'b0, 1'b0), 1'b0, '0);
    plan(stim_of(REQ_TARGET_FAM, 8'hA5, 1'b0, 1'b0, 1'b0), 1'b0, '0);
    plan(stim_of(REQ_SKIP_FAM, 8'h00, 1'b0, 1'b0, 1'b0), 1'b0, '0);
    plan(stim_of(REQ_VERIFY, 8'h00, 1'b0, 1'b0, 1'b0), 1'b0, '0);
    plan(stim_of(REQ_RESET_RESP, 8'h00, 1'b1, 1'b0, 1'b0), 1'b0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < probes.size(); k++) begin
      send(probes[k].stim, probes[k].known, probes[k].want, pred);
      sender_gap();
    end
    drain();

    counted = 0;
    populate_bus();
    while (counted < N_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        populate_bus();
      end else if (r < 14) begin
        send(noise_of(3'($urandom_range(0, 7))), 1'b0, '0, pred);
        sender_gap();
      end else if (r < 20) begin
        if (bus_count > 0 && $urandom_range(0, 1))
          send(stim_of(REQ_TARGET_FAM, bus_rom[$urandom_range(0, bus_count - 1)][7:0],
                       1'b0, 1'b0, 1'b0), 1'b0, '0, pred);
        else
          send(noise_of(REQ_TARGET_FAM), 1'b0, '0, pred);
        sender_gap();
        if ($urandom_range(0, 3) != 0) run_search(REQ_NEXT);
      end else if (r < 24) begin
        send(noise_of(REQ_SKIP_FAM), 1'b0, '0, pred);
        sender_gap();
        if ($urandom_range(0, 3) != 0) run_search(REQ_NEXT);
      end else if (r < 27) begin
        if (!hold_off) drain();
      end else begin
        r = $urandom_range(0, 99);
        run_search(r < 55 ? REQ_NEXT : (r < 80 ? REQ_FIRST : REQ_VERIFY));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
